>>> sv/pccc_pkg.sv
`timescale 1ns / 1ps
package pccc_pkg;

  localparam int COORD_W    = 16;
  localparam int CMD_W      = 2;
  localparam int THR_W      = 17;
  localparam int TOL_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;
  localparam int SEG_W      = 6;

  localparam int DEF_MAX_PATH_POINTS       = 64;
  localparam int DEF_MAX_CONSTRAINT_POINTS = 64;
  localparam int DEF_COORD_FRAC_BITS       = 10;

  localparam logic [CMD_W-1:0] CMD_PATH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CONS  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_THR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL = 1'b1;

  localparam logic [THR_W-1:0] THR_RESET = 17'd64225;

  // datapath widths
  localparam int DIFF_W     = COORD_W + 1;
  localparam int MUL_W      = 34;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int DEN_W      = 35;
  localparam int S_W        = 36;
  localparam int DIV_NUM_W  = 50;
  localparam int DIV_DEN_W  = S_W;
  localparam int DIV_Q_W    = 34;
  localparam int XD_W       = 35;
  localparam int LEN_IN_W   = 36;
  localparam int LEN_W      = 33;
  localparam int ARC_W      = 40;

  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } pt_t;

  typedef struct packed {
    logic                        start;
    logic signed [LEN_IN_W-1:0]  dx;
    logic signed [LEN_IN_W-1:0]  dy;
  } len_req_t;

  typedef struct packed {
    logic              done;
    logic [LEN_W-1:0]  len;
  } len_rsp_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_NUM_W-1:0]  num;
    logic [DIV_DEN_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DIV_Q_W-1:0]  q;
  } div_rsp_t;

endpackage

>>> sv/pccc_if.sv
`timescale 1ns / 1ps
interface pccc_in_if import pccc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           command;
  logic signed [COORD_W-1:0]  point_x;
  logic signed [COORD_W-1:0]  point_y;

  modport source (output valid, command, point_x, point_y, input ready);
  modport sink (input valid, command, point_x, point_y, output ready);
endinterface

interface pccc_out_if import pccc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              blocked;
  logic [SEG_W-1:0]  segment_index;

  modport source (output valid, blocked, segment_index, input ready);
  modport sink (input valid, blocked, segment_index, output ready);
endinterface

>>> sv/pccc_mem.sv
`timescale 1ns / 1ps
module pccc_mem import pccc_pkg::*; #(
  parameter int DEPTH = DEF_MAX_PATH_POINTS,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  pt_t           wr_data,
  input  logic [AW-1:0] rd_addr,
  output pt_t           rd_data
);

  pt_t mem_r [DEPTH];
  pt_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/pccc_div.sv
`timescale 1ns / 1ps
// unsigned truncating divide, one quotient bit per cycle
module pccc_div import pccc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_NUM_W);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIV_NUM_W-1:0]  num_r;
  logic [DIV_NUM_W-1:0]  quo_r;
  logic [DIV_DEN_W-1:0]  rem_r;
  logic [DIV_DEN_W-1:0]  den_r;
  logic [DIV_DEN_W:0]    trial;
  logic                  take;

  assign trial = {rem_r, num_r[DIV_NUM_W-1]};
  assign take  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        num_r  <= req.num;
        den_r  <= req.den;
        rem_r  <= '0;
        quo_r  <= '0;
      end else if (busy_r) begin
        num_r <= num_r << 1;
        quo_r <= {quo_r[DIV_NUM_W-2:0], take};
        rem_r <= take ? DIV_DEN_W'(trial - {1'b0, den_r}) : trial[DIV_DEN_W-1:0];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.q    = quo_r[DIV_Q_W-1:0];

endmodule

>>> sv/pccc_len.sv
`timescale 1ns / 1ps
// vector length: two squares, then a 32 step root, rounded to nearest
module pccc_len import pccc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  len_req_t req,
  output len_rsp_t rsp
);

  localparam int SQ_W   = 31;
  localparam int V_W    = 64;
  localparam int ROOT_W = 32;
  localparam int REM_W  = 34;
  localparam int CNT_W  = 5;

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_SQX  = 3'd1;
  localparam logic [2:0] L_SQY  = 3'd2;
  localparam logic [2:0] L_ROOT = 3'd3;
  localparam logic [2:0] L_FIN  = 3'd4;

  localparam logic [LEN_W-1:0] LEN_SAT = {1'b1, {(LEN_W-1){1'b0}}};

  logic [2:0]             st_r;
  logic                   done_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [SQ_W-1:0]        ax_r;
  logic [SQ_W-1:0]        ay_r;
  logic [V_W-1:0]         v_r;
  logic [ROOT_W-1:0]      root_r;
  logic [REM_W-1:0]       rem_r;
  logic [LEN_W-1:0]       len_r;

  logic [LEN_IN_W-1:0]    mx;
  logic [LEN_IN_W-1:0]    my;
  logic                   sat;
  logic [SQ_W-1:0]        mul_in;
  logic [2*SQ_W-1:0]      sq;
  logic [REM_W+1:0]       rem_t;
  logic [REM_W+1:0]       trial;
  logic                   ge;

  always_comb begin
    mx = req.dx < 0 ? LEN_IN_W'(-req.dx) : LEN_IN_W'(req.dx);
    my = req.dy < 0 ? LEN_IN_W'(-req.dy) : LEN_IN_W'(req.dy);
  end

  assign sat    = (|mx[LEN_IN_W-1:SQ_W]) || (|my[LEN_IN_W-1:SQ_W]);
  assign mul_in = (st_r == L_SQX) ? ax_r : ay_r;
  assign sq     = (2*SQ_W)'(mul_in) * (2*SQ_W)'(mul_in);
  assign rem_t  = {rem_r, v_r[V_W-1 -: 2]};
  assign trial  = (REM_W+2)'({root_r, 2'b01});
  assign ge     = rem_t >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= L_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        L_IDLE: begin
          if (req.start) begin
            if (sat) begin
              len_r  <= LEN_SAT;
              done_r <= 1'b1;
            end else begin
              ax_r <= mx[SQ_W-1:0];
              ay_r <= my[SQ_W-1:0];
              st_r <= L_SQX;
            end
          end
        end
        L_SQX: begin
          v_r  <= V_W'(sq);
          st_r <= L_SQY;
        end
        L_SQY: begin
          v_r    <= v_r + V_W'(sq);
          rem_r  <= '0;
          root_r <= '0;
          cnt_r  <= '0;
          st_r   <= L_ROOT;
        end
        L_ROOT: begin
          rem_r  <= ge ? REM_W'(rem_t - trial) : REM_W'(rem_t);
          root_r <= {root_r[ROOT_W-2:0], ge};
          v_r    <= v_r << 2;
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(ROOT_W - 1)) begin
            st_r <= L_FIN;
          end
        end
        L_FIN: begin
          // remainder above root: nearer to root + 1
          len_r  <= LEN_W'(root_r) + LEN_W'(rem_r > REM_W'(root_r));
          done_r <= 1'b1;
          st_r   <= L_IDLE;
        end
        default: st_r <= L_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.len  = len_r;

endmodule

>>> sv/path_crossing_conflict_check_unit.sv
`timescale 1ns / 1ps
// Append and clear items complete on acceptance; a run item holds the input for the whole scan.
// Run: each segment pair needs one length, a pair with a crossing two divides and two
// more lengths, each path segment one length; root is 32 steps, the divider 50 steps.
// Point stores are simple dual-port RAMs with registered reads; the scan is sequential.
// Synchronous active-low reset clears counts, registers to defaults and the output valid;
// point RAM contents are undefined until written.
module path_crossing_conflict_check_unit import pccc_pkg::*; #(
  parameter int MAX_PATH_POINTS       = DEF_MAX_PATH_POINTS,
  parameter int MAX_CONSTRAINT_POINTS = DEF_MAX_CONSTRAINT_POINTS,
  parameter int COORD_FRAC_BITS       = DEF_COORD_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pccc_in_if.sink               in_if,
  pccc_out_if.source            out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PA_W  = $clog2(MAX_PATH_POINTS);
  localparam int CA_W  = $clog2(MAX_CONSTRAINT_POINTS);
  localparam int PC_W  = $clog2(MAX_PATH_POINTS + 1);
  localparam int CC_W  = $clog2(MAX_CONSTRAINT_POINTS + 1);
  localparam int CMP_W = S_W + 16;

  localparam logic [TOL_W:0] TOL_RESET = (TOL_W+1)'(1) << COORD_FRAC_BITS;

  localparam logic [5:0] S_IDLE  = 6'd0;
  localparam logic [5:0] S_PRD0  = 6'd1;
  localparam logic [5:0] S_PRD1  = 6'd2;
  localparam logic [5:0] S_PRD2  = 6'd3;
  localparam logic [5:0] S_CRD0  = 6'd4;
  localparam logic [5:0] S_CRD1  = 6'd5;
  localparam logic [5:0] S_CRD2  = 6'd6;
  localparam logic [5:0] S_M0    = 6'd7;
  localparam logic [5:0] S_M1    = 6'd8;
  localparam logic [5:0] S_M2    = 6'd9;
  localparam logic [5:0] S_M3    = 6'd10;
  localparam logic [5:0] S_M4    = 6'd11;
  localparam logic [5:0] S_M5    = 6'd12;
  localparam logic [5:0] S_M6    = 6'd13;
  localparam logic [5:0] S_NORM  = 6'd14;
  localparam logic [5:0] S_TH0   = 6'd15;
  localparam logic [5:0] S_TH1   = 6'd16;
  localparam logic [5:0] S_X0    = 6'd17;
  localparam logic [5:0] S_X1    = 6'd18;
  localparam logic [5:0] S_XW    = 6'd19;
  localparam logic [5:0] S_Y0    = 6'd20;
  localparam logic [5:0] S_Y1    = 6'd21;
  localparam logic [5:0] S_YW    = 6'd22;
  localparam logic [5:0] S_G     = 6'd23;
  localparam logic [5:0] S_GW    = 6'd24;
  localparam logic [5:0] S_C     = 6'd25;
  localparam logic [5:0] S_CW    = 6'd26;
  localparam logic [5:0] S_CMP   = 6'd27;
  localparam logic [5:0] S_NEXT  = 6'd28;
  localparam logic [5:0] S_NEXTW = 6'd29;
  localparam logic [5:0] S_PSEG  = 6'd30;
  localparam logic [5:0] S_PSEGW = 6'd31;
  localparam logic [5:0] S_FIN   = 6'd32;

  logic [5:0]               state_r;
  logic [PC_W-1:0]          pcnt_r;
  logic [CC_W-1:0]          ccnt_r;
  logic [THR_W-1:0]         thr_r;
  logic [TOL_W:0]           tol_r;
  logic                     out_valid_r;
  logic                     out_blocked_r;
  logic [SEG_W-1:0]         out_seg_r;
  logic                     res_blocked_r;
  logic [SEG_W-1:0]         res_seg_r;

  logic [PA_W-1:0]          i_r;
  logic [CA_W-1:0]          j_r;
  logic signed [COORD_W-1:0] p1x_r;
  logic signed [COORD_W-1:0] p1y_r;
  logic signed [DIFF_W-1:0] xc_r;
  logic signed [DIFF_W-1:0] yc_r;
  logic signed [DIFF_W-1:0] xa_r;
  logic signed [DIFF_W-1:0] ya_r;
  logic signed [DIFF_W-1:0] xb_r;
  logic signed [DIFF_W-1:0] yb_r;
  logic signed [DEN_W-1:0]  den_r;
  logic signed [S_W-1:0]    s_r;
  logic signed [PROD_W-1:0] mul_p_r;
  logic                     neg_r;
  logic signed [XD_W-1:0]   xd_r;
  logic signed [XD_W-1:0]   yd_r;
  logic [ARC_W-1:0]         path_arc_r;
  logic [ARC_W-1:0]         cons_arc_r;
  logic [ARC_W-1:0]         g_r;
  logic [ARC_W-1:0]         cg_r;

  logic                     in_acc;
  logic [THR_W-1:0]         thr_eff;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [DIV_NUM_W-1:0] n_s;
  logic [DIV_NUM_W-1:0]     n_mag;
  logic [CMP_W-1:0]         s_sh;
  logic [ARC_W-1:0]         diff;
  logic                     more_cons;
  logic                     more_path;

  logic                     path_we;
  logic                     cons_we;
  pt_t                      wr_pt;
  logic [PA_W-1:0]          path_rd_addr;
  logic [CA_W-1:0]          cons_rd_addr;
  pt_t                      path_rd;
  pt_t                      cons_rd;

  len_req_t                 len_req;
  len_rsp_t                 len_rsp;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  assign in_acc       = in_if.valid && in_if.ready;
  assign in_if.ready  = (state_r == S_IDLE);
  assign out_if.valid         = out_valid_r;
  assign out_if.blocked       = out_blocked_r;
  assign out_if.segment_index = out_seg_r;

  // zero threshold acts as the smallest step so p + q = 0 never counts
  assign thr_eff = (thr_r == '0) ? THR_W'(1) : thr_r;

  assign wr_pt.x = in_if.point_x;
  assign wr_pt.y = in_if.point_y;
  assign path_we = in_acc && (in_if.command == CMD_PATH) &&
                   (pcnt_r < PC_W'(MAX_PATH_POINTS));
  assign cons_we = in_acc && (in_if.command == CMD_CONS) &&
                   (ccnt_r < CC_W'(MAX_CONSTRAINT_POINTS));
  assign path_rd_addr = (state_r == S_PRD1) ? PA_W'(i_r + 1'b1) : i_r;
  assign cons_rd_addr = (state_r == S_CRD1) ? CA_W'(j_r + 1'b1) : j_r;

  pccc_mem #(.DEPTH(MAX_PATH_POINTS)) u_path_mem (
    .clk     (clk),
    .wr_en   (path_we),
    .wr_addr (pcnt_r[PA_W-1:0]),
    .wr_data (wr_pt),
    .rd_addr (path_rd_addr),
    .rd_data (path_rd)
  );

  pccc_mem #(.DEPTH(MAX_CONSTRAINT_POINTS)) u_cons_mem (
    .clk     (clk),
    .wr_en   (cons_we),
    .wr_addr (ccnt_r[CA_W-1:0]),
    .wr_data (wr_pt),
    .rd_addr (cons_rd_addr),
    .rd_data (cons_rd)
  );

  pccc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  pccc_len u_len (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (len_req),
    .rsp   (len_rsp)
  );

  // shared multiplier for cross products, threshold and crossing scale
  always_comb begin
    case (state_r)
      S_M0:    begin mul_a = MUL_W'(xa_r); mul_b = MUL_W'(yb_r); end
      S_M1:    begin mul_a = MUL_W'(xb_r); mul_b = MUL_W'(ya_r); end
      S_M2:    begin mul_a = MUL_W'(xc_r); mul_b = MUL_W'(yb_r); end
      S_M3:    begin mul_a = MUL_W'(xb_r); mul_b = MUL_W'(yc_r); end
      S_M4:    begin mul_a = MUL_W'(xa_r); mul_b = MUL_W'(yc_r); end
      S_M5:    begin mul_a = MUL_W'(xc_r); mul_b = MUL_W'(ya_r); end
      S_TH0:   begin mul_a = signed'(MUL_W'(thr_eff)); mul_b = MUL_W'(den_r); end
      S_X0:    begin mul_a = MUL_W'(xc_r); mul_b = MUL_W'(den_r); end
      S_Y0:    begin mul_a = MUL_W'(yc_r); mul_b = MUL_W'(den_r); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
  end

  always_comb begin
    n_s   = DIV_NUM_W'(mul_p_r);
    n_mag = n_s[DIV_NUM_W-1] ? DIV_NUM_W'(-n_s) : DIV_NUM_W'(n_s);
    div_req.start = (state_r == S_X1) || (state_r == S_Y1);
    div_req.num   = n_mag + DIV_NUM_W'(s_r[S_W-1:1]);
    div_req.den   = DIV_DEN_W'(s_r);
  end

  always_comb begin
    len_req.start = 1'b0;
    len_req.dx    = '0;
    len_req.dy    = '0;
    case (state_r)
      S_G: begin
        len_req.start = 1'b1;
        len_req.dx    = LEN_IN_W'(xd_r);
        len_req.dy    = LEN_IN_W'(yd_r);
      end
      S_C: begin
        len_req.start = 1'b1;
        len_req.dx    = LEN_IN_W'(xd_r) - LEN_IN_W'(xa_r);
        len_req.dy    = LEN_IN_W'(yd_r) - LEN_IN_W'(ya_r);
      end
      S_NEXT: begin
        len_req.start = 1'b1;
        len_req.dx    = LEN_IN_W'(xb_r) - LEN_IN_W'(xa_r);
        len_req.dy    = LEN_IN_W'(yb_r) - LEN_IN_W'(ya_r);
      end
      S_PSEG: begin
        len_req.start = 1'b1;
        len_req.dx    = LEN_IN_W'(xc_r);
        len_req.dy    = LEN_IN_W'(yc_r);
      end
      default: ;
    endcase
  end

  assign s_sh      = {s_r[S_W-1:0], 16'b0};
  assign diff      = (g_r > cg_r) ? (g_r - cg_r) : (cg_r - g_r);
  assign more_cons = ((CC_W+1)'(j_r) + (CC_W+1)'(2)) < (CC_W+1)'(ccnt_r);
  assign more_path = ((PC_W+1)'(i_r) + (PC_W+1)'(2)) < (PC_W+1)'(pcnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pcnt_r      <= '0;
      ccnt_r      <= '0;
      thr_r       <= THR_RESET;
      tol_r       <= TOL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_THR: thr_r <= cfg_wdata[THR_W-1:0];
          CFG_TOL: tol_r <= {1'b0, cfg_wdata[TOL_W-1:0]};
          default: ;
        endcase
      end

      // in S_FIN the slot is refilled below instead
      if (out_valid_r && out_if.ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_if.command)
              CMD_PATH: if (path_we) pcnt_r <= pcnt_r + 1'b1;
              CMD_CONS: if (cons_we) ccnt_r <= ccnt_r + 1'b1;
              CMD_CLEAR: begin
                pcnt_r <= '0;
                ccnt_r <= '0;
              end
              CMD_RUN: begin
                if (pcnt_r < PC_W'(2) || ccnt_r < CC_W'(2)) begin
                  res_blocked_r <= 1'b0;
                  res_seg_r     <= '0;
                  state_r       <= S_FIN;
                end else begin
                  i_r        <= '0;
                  path_arc_r <= '0;
                  state_r    <= S_PRD0;
                end
              end
              default: ;
            endcase
          end
        end
        S_PRD0: state_r <= S_PRD1;
        S_PRD1: begin
          p1x_r   <= path_rd.x;
          p1y_r   <= path_rd.y;
          state_r <= S_PRD2;
        end
        S_PRD2: begin
          xc_r       <= DIFF_W'(path_rd.x) - DIFF_W'(p1x_r);
          yc_r       <= DIFF_W'(path_rd.y) - DIFF_W'(p1y_r);
          j_r        <= '0;
          cons_arc_r <= '0;
          state_r    <= S_CRD0;
        end
        S_CRD0: state_r <= S_CRD1;
        S_CRD1: begin
          xa_r    <= DIFF_W'(cons_rd.x) - DIFF_W'(p1x_r);
          ya_r    <= DIFF_W'(cons_rd.y) - DIFF_W'(p1y_r);
          state_r <= S_CRD2;
        end
        S_CRD2: begin
          xb_r    <= DIFF_W'(cons_rd.x) - DIFF_W'(p1x_r);
          yb_r    <= DIFF_W'(cons_rd.y) - DIFF_W'(p1y_r);
          state_r <= S_M0;
        end
        // product issued in the previous state arrives in mul_p_r
        S_M0: state_r <= S_M1;
        S_M1: begin
          den_r   <= DEN_W'(mul_p_r);
          state_r <= S_M2;
        end
        S_M2: begin
          den_r   <= den_r - DEN_W'(mul_p_r);
          state_r <= S_M3;
        end
        S_M3: begin
          s_r     <= S_W'(mul_p_r);
          state_r <= S_M4;
        end
        S_M4: begin
          s_r     <= s_r - S_W'(mul_p_r);
          state_r <= S_M5;
        end
        S_M5: begin
          s_r     <= s_r + S_W'(mul_p_r);
          state_r <= S_M6;
        end
        S_M6: begin
          s_r     <= s_r - S_W'(mul_p_r);
          state_r <= S_NORM;
        end
        S_NORM: begin
          if (den_r == '0) begin
            state_r <= S_NEXT;
          end else begin
            if (den_r < 0) begin
              den_r <= -den_r;
              s_r   <= -s_r;
            end
            state_r <= S_TH0;
          end
        end
        S_TH0: state_r <= (s_r <= 0) ? S_NEXT : S_TH1;
        S_TH1: state_r <= (s_sh >= CMP_W'(mul_p_r)) ? S_X0 : S_NEXT;
        S_X0:  state_r <= S_X1;
        S_X1: begin
          neg_r   <= xc_r < 0;
          state_r <= S_XW;
        end
        S_XW: begin
          if (div_rsp.done) begin
            xd_r    <= neg_r ? -signed'(XD_W'(div_rsp.q)) : signed'(XD_W'(div_rsp.q));
            state_r <= S_Y0;
          end
        end
        S_Y0:  state_r <= S_Y1;
        S_Y1: begin
          neg_r   <= yc_r < 0;
          state_r <= S_YW;
        end
        S_YW: begin
          if (div_rsp.done) begin
            yd_r    <= neg_r ? -signed'(XD_W'(div_rsp.q)) : signed'(XD_W'(div_rsp.q));
            state_r <= S_G;
          end
        end
        S_G: state_r <= S_GW;
        S_GW: begin
          if (len_rsp.done) begin
            g_r     <= path_arc_r + ARC_W'(len_rsp.len);
            state_r <= S_C;
          end
        end
        S_C: state_r <= S_CW;
        S_CW: begin
          if (len_rsp.done) begin
            cg_r    <= cons_arc_r + ARC_W'(len_rsp.len);
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          if (diff < ARC_W'(tol_r)) begin
            res_blocked_r <= 1'b1;
            res_seg_r     <= SEG_W'(i_r);
            state_r       <= S_FIN;
          end else begin
            state_r <= S_NEXT;
          end
        end
        S_NEXT: state_r <= S_NEXTW;
        S_NEXTW: begin
          if (len_rsp.done) begin
            cons_arc_r <= cons_arc_r + ARC_W'(len_rsp.len);
            if (more_cons) begin
              j_r     <= j_r + 1'b1;
              state_r <= S_CRD0;
            end else begin
              state_r <= S_PSEG;
            end
          end
        end
        S_PSEG: state_r <= S_PSEGW;
        S_PSEGW: begin
          if (len_rsp.done) begin
            path_arc_r <= path_arc_r + ARC_W'(len_rsp.len);
            if (more_path) begin
              i_r     <= i_r + 1'b1;
              state_r <= S_PRD0;
            end else begin
              res_blocked_r <= 1'b0;
              res_seg_r     <= '0;
              state_r       <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_if.ready) begin
            out_valid_r   <= 1'b1;
            out_blocked_r <= res_blocked_r;
            out_seg_r     <= res_seg_r;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/pccc_chk.sv
`timescale 1ns / 1ps
module pccc_chk import pccc_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_blocked,
  input logic [SEG_W-1:0] out_segment_index
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_blocked) && $stable(out_segment_index))
    else $error("result item changed while stalled");

  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_blocked |-> out_segment_index == '0)
    else $error("segment index set on a not blocked result");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind path_crossing_conflict_check_unit pccc_chk u_pccc_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .out_blocked       (out_if.blocked),
  .out_segment_index (out_if.segment_index)
);
